FILE: design/rdzs_pkg.sv
// rdzs_pkg: shared types and constants of the radial dead-zone scaler
// no dependencies; imported by every design module of the block
`default_nettype none

package rdzs_pkg;

    // magnitude clip limit and the radius width it implies
    localparam logic [14:0] MAG_LIMIT = 15'h7fff;

    // square root: 16 result bits, two per stage
    localparam int SQ_STAGES = 8;

    // division: 16 fraction bits after the integer bit, two per stage
    localparam int DIV_STAGES = 8;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_axes;

    typedef struct packed {
        logic        dead;
        logic        den_zero;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] abs_x;
        logic [15:0] abs_y;
    } t_div_side;

    typedef struct packed {
        logic [14:0] rem;
        logic [16:0] quo;
    } t_div_state;

endpackage

`default_nettype wire

FILE: design/rdzs_isqrt.sv
// rdzs_isqrt: pipelined floor square root of a 32-bit value, two result bits per stage
// depends on rdzs_pkg; carries the raw axes alongside the root
`default_nettype none

module rdzs_isqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [31:0]    i_radicand,
    input  wire rdzs_pkg::t_axes i_side,
    output logic                o_valid,
    output logic [15:0]         o_root,
    output rdzs_pkg::t_axes     o_side
);
    import rdzs_pkg::*;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] root;
    } t_sq_state;

    // one digit of the restoring square root
    function automatic t_sq_state sq_step(input t_sq_state s, input logic [1:0] bits);
        logic [18:0] rem_sh;
        logic [18:0] trial;
        t_sq_state   n;
        rem_sh = {s.rem, bits};
        trial  = {1'b0, s.root, 2'b01};
        if (rem_sh >= trial) begin
            n.rem  = 17'(rem_sh - trial);
            n.root = {s.root[14:0], 1'b1};
        end else begin
            n.rem  = rem_sh[16:0];
            n.root = {s.root[14:0], 1'b0};
        end
        return n;
    endfunction

    logic        r_vld  [SQ_STAGES];
    logic [27:0] r_rad  [SQ_STAGES];
    t_sq_state   r_sq   [SQ_STAGES];
    t_axes       r_side [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        logic        v_in;
        logic [31:0] rad_in;
        t_sq_state   st_in;
        t_axes       side_in;
        t_sq_state   st_mid;
        t_sq_state   n_sq;
        logic [27:0] n_rad;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_radicand;
            assign st_in   = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[s-1];
            assign rad_in  = {r_rad[s-1], 4'b0000};
            assign st_in   = r_sq[s-1];
            assign side_in = r_side[s-1];
        end

        always_comb begin
            st_mid = sq_step(st_in, rad_in[31:30]);
            n_sq   = sq_step(st_mid, rad_in[29:28]);
            n_rad  = rad_in[27:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[s]  <= n_rad;
            r_sq[s]   <= n_sq;
            r_side[s] <= side_in;
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_sq[SQ_STAGES-1].root;
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

`default_nettype wire

FILE: design/rdzs_qdiv.sv
// rdzs_qdiv: pipelined restoring division giving the q1.16 scale factor
// depends on rdzs_pkg; the integer bit and initial remainder come in precomputed
`default_nettype none

module rdzs_qdiv (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire rdzs_pkg::t_div_state i_state,
    input  wire logic [14:0]     i_den,
    input  wire rdzs_pkg::t_div_side  i_side,
    output logic                 o_valid,
    output logic [16:0]          o_factor,
    output rdzs_pkg::t_div_side  o_side
);
    import rdzs_pkg::*;

    // one quotient bit of the long division
    function automatic t_div_state div_step(input t_div_state s, input logic [14:0] den);
        logic [15:0] sh;
        t_div_state  n;
        sh = {s.rem, 1'b0};
        if (sh >= {1'b0, den}) begin
            n.rem = 15'(sh - {1'b0, den});
            n.quo = {s.quo[15:0], 1'b1};
        end else begin
            n.rem = sh[14:0];
            n.quo = {s.quo[15:0], 1'b0};
        end
        return n;
    endfunction

    logic        r_vld  [DIV_STAGES];
    t_div_state  r_dv   [DIV_STAGES];
    logic [14:0] r_den  [DIV_STAGES];
    t_div_side   r_side [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic        v_in;
        t_div_state  st_in;
        logic [14:0] den_in;
        t_div_side   side_in;
        t_div_state  st_mid;
        t_div_state  n_dv;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign st_in   = i_state;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[s-1];
            assign st_in   = r_dv[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        always_comb begin
            st_mid = div_step(st_in, den_in);
            n_dv   = div_step(st_mid, den_in);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[s]   <= n_dv;
            r_den[s]  <= den_in;
            r_side[s] <= side_in;
        end
    end

    assign o_valid  = r_vld[DIV_STAGES-1];
    // zero divisor means the factor is zero
    assign o_factor = r_side[DIV_STAGES-1].den_zero ? 17'd0 : r_dv[DIV_STAGES-1].quo;
    assign o_side   = r_side[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: design/rdzs_scale.sv
// rdzs_scale: multiplies each axis magnitude by the factor and restores the sign
// depends on rdzs_pkg; two register stages, the second one drives the result ports
`default_nettype none

module rdzs_scale (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [16:0]    i_factor,
    input  wire rdzs_pkg::t_div_side i_side,
    output logic                o_valid,
    output logic signed [15:0]  o_scaled_x,
    output logic signed [15:0]  o_scaled_y,
    output logic                o_in_dead_zone
);
    import rdzs_pkg::*;

    logic        r_p_vld;
    logic [31:0] r_px;
    logic [31:0] r_py;
    t_div_side   r_p_side;
    logic [31:0] n_px;
    logic [31:0] n_py;

    logic               r_vld;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic               r_dead;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;

    // product is at most 2^31 since factor <= 2^16 and |v| <= 2^15
    always_comb begin
        n_px = 32'({17'd0, i_side.abs_x} * {16'd0, i_factor});
        n_py = 32'({17'd0, i_side.abs_y} * {16'd0, i_factor});
    end

    always_comb begin
        mag_x = r_px[31:16];
        mag_y = r_py[31:16];
        if (r_p_side.dead) begin
            n_x = '0;
            n_y = '0;
        end else begin
            n_x = r_p_side.neg_x ? $signed(16'(-mag_x)) : $signed(mag_x);
            n_y = r_p_side.neg_y ? $signed(16'(-mag_y)) : $signed(mag_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_p_vld <= i_valid;
            r_vld   <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_py     <= n_py;
        r_p_side <= i_side;
        r_x      <= n_x;
        r_y      <= n_y;
        r_dead   <= r_p_side.dead;
    end

    assign o_valid        = r_vld;
    assign o_scaled_x     = r_x;
    assign o_scaled_y     = r_y;
    assign o_in_dead_zone = r_dead;

endmodule

`default_nettype wire

FILE: design/radial_dead_zone_scaler.sv
// radial_dead_zone_scaler: top level of the circular dead-zone scaler
// depends on rdzs_pkg, rdzs_isqrt, rdzs_qdiv and rdzs_scale
//
// usage:
//   input: a sample (i_stick_x, i_stick_y) transfers in at a rising edge where start
//   is high and busy is low. busy is always low, so a sample may enter every cycle.
//   config: i_cfg_we writes i_cfg_wdata into the dead-zone radius; write it only while
//   no sample is in flight.
//   output: o_valid is high for exactly one cycle per sample, with o_scaled_x,
//   o_scaled_y and o_in_dead_zone; the result transfers out at the edge ending
//   that cycle and cannot be held off.
//   throughput: one sample per cycle; the chain is input register, squares, sum,
//   eight square-root stages (two root bits each), a factor setup stage, eight
//   division stages (two quotient bits each), a multiply stage and an output stage.
//   reset: synchronous, active low; clears the radius to 0 and all stage valid bits,
//   so nothing in flight survives reset.
`default_nettype none

module radial_dead_zone_scaler (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_stick_x,
    input  wire logic signed [15:0] i_stick_y,
    input  wire logic               i_cfg_we,
    input  wire logic [14:0]        i_cfg_wdata,
    output logic                    o_valid,
    output logic signed [15:0]      o_scaled_x,
    output logic signed [15:0]      o_scaled_y,
    output logic                    o_in_dead_zone
);
    import rdzs_pkg::*;

    logic [14:0] r_radius;

    // input stage
    logic  r_in_vld;
    t_axes r_in;

    // squares stage
    logic        r_sq_vld;
    logic [30:0] r_sqx;
    logic [30:0] r_sqy;
    t_axes       r_sq_side;
    logic [30:0] n_sqx;
    logic [30:0] n_sqy;

    // sum stage
    logic        r_sum_vld;
    logic [31:0] r_sum;
    t_axes       r_sum_side;

    // square root outputs
    logic        rt_vld;
    logic [15:0] rt_mag;
    t_axes       rt_side;

    // factor setup stage
    logic        r_pr_vld;
    t_div_state  r_pr_state;
    logic [14:0] r_pr_den;
    t_div_side   r_pr_side;
    logic        dead;
    logic [14:0] clipped;
    logic [14:0] num;
    logic [14:0] den;
    logic        int_bit;
    t_div_state  n_pr_state;
    t_div_side   n_pr_side;

    // division outputs
    logic        dv_vld;
    logic [16:0] dv_factor;
    t_div_side   dv_side;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_sqx = 31'($unsigned(32'(r_in.x * r_in.x)));
        n_sqy = 31'($unsigned(32'(r_in.y * r_in.y)));
    end

    always_comb begin
        dead    = rt_mag <= {1'b0, r_radius};
        clipped = (rt_mag > {1'b0, MAG_LIMIT}) ? MAG_LIMIT : rt_mag[14:0];
        num     = dead ? 15'd0 : 15'(clipped - r_radius);
        den     = 15'(MAG_LIMIT - r_radius);
        // num never exceeds den, so the integer bit is set only when they match
        int_bit = num >= den;
        n_pr_state.quo = {16'd0, int_bit};
        n_pr_state.rem = int_bit ? 15'(num - den) : num;
        n_pr_side.dead     = dead;
        n_pr_side.den_zero = den == 15'd0;
        n_pr_side.neg_x    = rt_side.x[15];
        n_pr_side.neg_y    = rt_side.y[15];
        n_pr_side.abs_x    = rt_side.x[15] ? 16'(-rt_side.x) : rt_side.x;
        n_pr_side.abs_y    = rt_side.y[15] ? 16'(-rt_side.y) : rt_side.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_pr_vld  <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_sq_vld  <= r_in_vld;
            r_sum_vld <= r_sq_vld;
            r_pr_vld  <= rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in.x     <= i_stick_x;
        r_in.y     <= i_stick_y;
        r_sqx      <= n_sqx;
        r_sqy      <= n_sqy;
        r_sq_side  <= r_in;
        r_sum      <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_sum_side <= r_sq_side;
        r_pr_state <= n_pr_state;
        r_pr_den   <= den;
        r_pr_side  <= n_pr_side;
    end

    rdzs_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_sum_vld),
        .i_radicand (r_sum),
        .i_side     (r_sum_side),
        .o_valid    (rt_vld),
        .o_root     (rt_mag),
        .o_side     (rt_side)
    );

    rdzs_qdiv u_qdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_pr_vld),
        .i_state  (r_pr_state),
        .i_den    (r_pr_den),
        .i_side   (r_pr_side),
        .o_valid  (dv_vld),
        .o_factor (dv_factor),
        .o_side   (dv_side)
    );

    rdzs_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (dv_vld),
        .i_factor       (dv_factor),
        .i_side         (dv_side),
        .o_valid        (o_valid),
        .o_scaled_x     (o_scaled_x),
        .o_scaled_y     (o_scaled_y),
        .o_in_dead_zone (o_in_dead_zone)
    );

endmodule

`default_nettype wire

FILE: design/rdzs_chk.sv
// rdzs_chk: port-level checks of the radial dead-zone scaler over time
// depends only on the top level's ports; bound to radial_dead_zone_scaler below
`default_nettype none

module rdzs_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic signed [15:0] i_stick_x,
    input wire logic signed [15:0] i_stick_y,
    input wire logic               o_valid,
    input wire logic signed [15:0] o_scaled_x,
    input wire logic signed [15:0] o_scaled_y,
    input wire logic               o_in_dead_zone
);
    localparam int Lat = 22;

    // cycles since reset released, saturating
    logic [4:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != 5'h1f) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised although the pipeline never stalls");

    a_one_result_per_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 5'(Lat)) |-> (o_valid == $past(start && !busy, Lat)))
        else $error("result strobe does not match an input transfer");

    a_dead_zone_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_dead_zone) |-> (o_scaled_x == 16'sd0 && o_scaled_y == 16'sd0))
        else $error("dead-zone result with nonzero axis");

    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 5'(Lat) && o_valid && o_scaled_x != 16'sd0)
            |-> (o_scaled_x[15] == $past(i_stick_x[15], Lat)))
        else $error("scaled x sign differs from input sign");

    a_sign_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 5'(Lat) && o_valid && o_scaled_y != 16'sd0)
            |-> (o_scaled_y[15] == $past(i_stick_y[15], Lat)))
        else $error("scaled y sign differs from input sign");

endmodule

bind radial_dead_zone_scaler rdzs_chk u_rdzs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_stick_x      (i_stick_x),
    .i_stick_y      (i_stick_y),
    .o_valid        (o_valid),
    .o_scaled_x     (o_scaled_x),
    .o_scaled_y     (o_scaled_y),
    .o_in_dead_zone (o_in_dead_zone)
);

`default_nettype wire
